// File: rtl/rwts_pkg.sv
// Shared types and constants of the wall texture sampler.
`default_nettype none
package rwts_pkg;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		FACE_NORTH = 2'd0,
		FACE_SOUTH = 2'd1,
		FACE_WEST  = 2'd2,
		FACE_EAST  = 2'd3
	} face_t;

	localparam int TEXELS_PER_FACE_DEF = 4096;
	localparam int TEXEL_W = 32;
	localparam int FRAC_W  = 16;
	localparam int DIM_W   = 7;
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 3;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	localparam logic [REG_IDX_W-1:0] REG_NORTH_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NORTH_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SOUTH_WIDTH  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SOUTH_HEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WEST_WIDTH   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WEST_HEIGHT  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_EAST_WIDTH   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_EAST_HEIGHT  = 3'd7;

endpackage
`default_nettype wire

// File: rtl/raycast_wall_texture_sampler.sv
// Throughput: one request per cycle, loads and samples alike, when the output is not stalled.
// The texel memory port is shared by both, and each request uses it once, as it enters
// the last stage.
// The row fraction comes from a 16-stage pipelined restoring divider.
// Reset clears all stage valid bits and sets every face dimension to 64.
// The texel memory is not cleared; unwritten texels read as unknown data.
`default_nettype none
module raycast_wall_texture_sampler import rwts_pkg::*; #(
	parameter int TEXELS_PER_FACE = TEXELS_PER_FACE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 command,
	input  wire logic [13:0]          texel_address,
	input  wire logic [31:0]          texel_data,
	input  wire logic [25:0]          player_x,
	input  wire logic [25:0]          player_y,
	input  wire logic signed [17:0]   ray_dir_x,
	input  wire logic signed [17:0]   ray_dir_y,
	input  wire logic [25:0]          wall_distance,
	input  wire logic                 hit_side,
	input  wire logic [11:0]          screen_row,
	input  wire logic signed [15:0]   strip_top,
	input  wire logic [15:0]          strip_rows,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [31:0]               colour,
	output logic [1:0]                face
);

	// Faces are assumed to be a power of two in size, so a face base is a concatenation.
	localparam int OFF_W   = $clog2(TEXELS_PER_FACE);
	localparam int ADDR_W  = OFF_W + 2;
	localparam int DEPTH   = 4 * TEXELS_PER_FACE;
	localparam int LEXT_W  = (ADDR_W > 14) ? ADDR_W : 14;
	localparam int OEXT_W  = (OFF_W > 15) ? OFF_W : 15;
	localparam int S_A     = 0;
	localparam int S_B     = 1;
	localparam int S_D0    = 2;
	localparam int S_E     = S_D0 + FRAC_W;
	localparam int S_F     = S_E + 1;
	localparam int S_M     = S_F + 1;
	localparam int NS      = S_M + 1;

	typedef struct packed {
		cmd_t                 cmd;
		face_t                fc;
		logic [ADDR_W-1:0]    laddr;
		logic [TEXEL_W-1:0]   data;
		logic [25:0]          pos;
		logic signed [44:0]   prod;
		logic signed [17:0]   num;
		logic [15:0]          wh;
		logic [DIM_W-1:0]     w;
		logic [DIM_W-1:0]     h;
		logic [16:0]          f;
		logic [DIM_W-1:0]     x;
		logic                 yzero;
		logic                 ysat;
		logic [15:0]          rem;
		logic [FRAC_W-1:0]    q;
		logic [DIM_W-1:0]     y;
		logic [ADDR_W-1:0]    idx;
	} item_t;

	logic [DIM_W-1:0]   dims_q [NUM_REGS];
	logic               valid_s [NS];
	item_t              st_s [NS];
	item_t              nxt [NS];
	logic               take [NS];
	logic               leave [NS];
	logic               free [NS];
	logic [TEXEL_W-1:0] mem [DEPTH];
	logic [TEXEL_W-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) dims_q[i] <= DIM_RESET;
		end else if (cfg_write) begin
			dims_q[cfg_index] <= cfg_data;
		end
	end

	// Handshake chain: a stage frees when its item moves on, bubbles collapse.
	// A load has already written the memory when it reaches the last stage and gives no
	// result, so it leaves that stage whatever the output does.
	always_comb begin
		for (int k = NS - 1; k >= 0; k--) begin
			if (k == NS - 1) leave[k] = valid_s[k] && (!out_stall || st_s[k].cmd == CMD_LOAD);
			else             leave[k] = valid_s[k] && free[k+1];
			free[k] = !valid_s[k] || leave[k];
		end
		for (int k = 0; k < NS; k++) begin
			if (k == 0) take[k] = in_valid && free[0];
			else        take[k] = leave[k-1];
		end
	end

	assign in_stall  = !free[0];
	assign out_valid = valid_s[S_M] && (st_s[S_M].cmd == CMD_SAMPLE);
	assign colour    = rd_q;
	assign face      = st_s[S_M].fc;

	always_comb begin
		logic                 side;
		logic [DIM_W-1:0]     wsel;
		logic [DIM_W-1:0]     hsel;
		logic [LEXT_W-1:0]    lext;
		logic signed [45:0]   hit;
		logic [31:0]          mag;
		logic [23:0]          wf;
		logic [16:0]          r2;
		logic [22:0]          hq;
		logic [DIM_W-1:0]     yv;
		logic [OEXT_W-1:0]    off;
		item_t                a;

		side = hit_side;
		a = '0;
		a.cmd = cmd_t'(command);
		if (side) a.fc = (ray_dir_y < 0) ? FACE_NORTH : FACE_SOUTH;
		else      a.fc = (ray_dir_x < 0) ? FACE_WEST : FACE_EAST;
		unique case (a.fc)
			FACE_NORTH: begin wsel = dims_q[REG_NORTH_WIDTH]; hsel = dims_q[REG_NORTH_HEIGHT]; end
			FACE_SOUTH: begin wsel = dims_q[REG_SOUTH_WIDTH]; hsel = dims_q[REG_SOUTH_HEIGHT]; end
			FACE_WEST:  begin wsel = dims_q[REG_WEST_WIDTH];  hsel = dims_q[REG_WEST_HEIGHT];  end
			FACE_EAST:  begin wsel = dims_q[REG_EAST_WIDTH];  hsel = dims_q[REG_EAST_HEIGHT];  end
			default:    begin wsel = dims_q[REG_NORTH_WIDTH]; hsel = dims_q[REG_NORTH_HEIGHT]; end
		endcase
		a.w = (wsel == '0) ? DIM_W'(1) : wsel;
		a.h = (hsel == '0) ? DIM_W'(1) : hsel;
		lext = LEXT_W'(texel_address);
		a.laddr = lext[ADDR_W-1:0];
		a.data = texel_data;
		a.pos = side ? player_x : player_y;
		a.prod = (side ? ray_dir_x : ray_dir_y) * $signed({1'b0, wall_distance});
		a.num = $signed({6'b0, screen_row}) - 18'(strip_top);
		a.wh = (strip_rows == '0) ? 16'd1 : strip_rows;
		nxt[S_A] = a;

		// Hit position, wall fraction and the divider setup.
		a = st_s[S_A];
		hit = $signed({4'b0, a.pos, 16'b0}) + 46'(a.prod);
		mag = (hit < 0) ? 32'(-hit) : hit[31:0];
		if (a.fc == FACE_SOUTH || a.fc == FACE_WEST) a.f = 17'h10000 - {1'b0, mag[31:16]};
		else                                         a.f = {1'b0, mag[31:16]};
		a.yzero = (a.num <= 0);
		a.ysat  = !a.yzero && (a.num >= $signed({2'b0, a.wh}));
		a.rem   = (a.yzero || a.ysat) ? 16'd0 : a.num[15:0];
		a.q     = '0;
		nxt[S_B] = a;

		// One quotient bit per stage; the first stage also scales the column.
		for (int k = 0; k < FRAC_W; k++) begin
			a = st_s[S_D0 + k - 1];
			if (k == 0) begin
				wf = a.w * a.f;
				a.x = (wf[23:16] >= {1'b0, a.w}) ? a.w - DIM_W'(1) : wf[22:16];
			end
			r2 = {a.rem, 1'b0};
			if (r2 >= {1'b0, a.wh}) begin
				a.rem = 16'(r2 - {1'b0, a.wh});
				a.q = {a.q[FRAC_W-2:0], 1'b1};
			end else begin
				a.rem = r2[15:0];
				a.q = {a.q[FRAC_W-2:0], 1'b0};
			end
			nxt[S_D0 + k] = a;
		end

		a = st_s[S_E - 1];
		hq = a.h * a.q;
		if (a.yzero)     yv = '0;
		else if (a.ysat) yv = a.h - DIM_W'(1);
		else             yv = hq[22:16];
		a.y = (yv >= a.h) ? a.h - DIM_W'(1) : yv;
		nxt[S_E] = a;

		a = st_s[S_E];
		off = OEXT_W'(a.y * a.w) + OEXT_W'(a.x);
		a.idx = {a.fc, off[OFF_W-1:0]};
		nxt[S_F] = a;

		nxt[S_M] = st_s[S_F];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) valid_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < NS; k++) valid_s[k] <= take[k] || (valid_s[k] && !leave[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (take[k]) st_s[k] <= nxt[k];
		end
	end

	// Loads and samples reach the memory in request order, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (take[S_M]) begin
			if (st_s[S_F].cmd == CMD_LOAD) mem[st_s[S_F].laddr] <= st_s[S_F].data;
			else                           rd_q <= mem[st_s[S_F].idx];
		end
	end

`ifndef SYNTHESIS
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s[S_A] |-> !in_stall)
		else $error("input stalled with an empty first stage");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s[S_A])
		else $error("accepted request lost");
	a_row_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[S_B] |-> !(st_s[S_B].yzero && st_s[S_B].ysat))
		else $error("row both above and past the strip");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[S_F] && st_s[S_F].cmd == CMD_SAMPLE) |-> (st_s[S_F].y < st_s[S_F].h))
		else $error("texel row out of range");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[S_F] && st_s[S_F].cmd == CMD_SAMPLE) |-> (st_s[S_F].x < st_s[S_F].w))
		else $error("texel column out of range");
`endif

endmodule
`default_nettype wire

// File: bench/rwts_checker.sv
// Checker for the wall texture sampler: tracks loads and settings, predicts samples, compares.
`timescale 1ns / 1ps
module rwts_checker import rwts_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic                 command,
	input  wire logic [13:0]          texel_address,
	input  wire logic [31:0]          texel_data,
	input  wire logic [25:0]          player_x,
	input  wire logic [25:0]          player_y,
	input  wire logic signed [17:0]   ray_dir_x,
	input  wire logic signed [17:0]   ray_dir_y,
	input  wire logic [25:0]          wall_distance,
	input  wire logic                 hit_side,
	input  wire logic [11:0]          screen_row,
	input  wire logic signed [15:0]   strip_top,
	input  wire logic [15:0]          strip_rows,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [31:0]          colour,
	input  wire logic [1:0]           face,
	output int                        errors,
	output int                        pending
);

	typedef struct packed {
		logic [31:0] colour;
		face_t       face;
		logic        known;
	} sample_t;

	logic [31:0]      texels [4*TEXELS_PER_FACE_DEF];
	bit               texel_known [4*TEXELS_PER_FACE_DEF];
	logic [DIM_W-1:0] dims [NUM_REGS];
	sample_t          expected_samples [$];

	// Wall fraction in Q.16: bits 31..16 of |pos*2^16 + dir*span|.
	function automatic longint wall_fraction(logic [25:0] pos, logic signed [17:0] dir,
			logic [25:0] span);
		longint hit;
		hit = (longint'(pos) <<< 16) + longint'(dir) * longint'(span);
		if (hit < 0)
			hit = -hit;
		return (hit >>> 16) & 64'hFFFF;
	endfunction

	function automatic longint dim_used(int idx);
		return (dims[idx] == 0) ? 1 : longint'(dims[idx]);
	endfunction

	function automatic sample_t predict_sample();
		sample_t r;
		face_t   fc;
		longint  f, w, h, x, y, q, num, wh, idx;
		if (hit_side)
			fc = (ray_dir_y < 0) ? FACE_NORTH : FACE_SOUTH;
		else
			fc = (ray_dir_x < 0) ? FACE_WEST : FACE_EAST;
		if (hit_side)
			f = wall_fraction(player_x, ray_dir_x, wall_distance);
		else
			f = wall_fraction(player_y, ray_dir_y, wall_distance);
		// South and west faces are seen mirrored.
		if (fc == FACE_SOUTH || fc == FACE_WEST)
			f = 65536 - f;
		w = dim_used(int'(fc) * 2);
		h = dim_used(int'(fc) * 2 + 1);
		x = (w * f) >>> 16;
		if (x >= w)
			x = w - 1;
		num = longint'(screen_row) - longint'(strip_top);
		wh = (strip_rows == 0) ? 1 : longint'(strip_rows);
		if (num <= 0) begin
			y = 0;
		end else begin
			q = (num <<< 16) / wh;
			y = (h * q) >>> 16;
			if (y >= h)
				y = h - 1;
		end
		idx = longint'(fc) * TEXELS_PER_FACE_DEF + (y * w + x) % TEXELS_PER_FACE_DEF;
		r.colour = texels[idx];
		r.face = fc;
		// A texel that was never loaded has no defined colour, so only the face is checked.
		r.known = texel_known[idx];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t e;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				dims[i] = DIM_RESET;
			expected_samples.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_write)
				dims[cfg_index] = cfg_data;
			if (in_valid && !in_stall) begin
				if (cmd_t'(command) == CMD_LOAD) begin
					texels[texel_address] = texel_data;
					texel_known[texel_address] = 1'b1;
				end else begin
					expected_samples.push_back(predict_sample());
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					$error("unexpected result: colour %h face %0d", colour, face);
					errors++;
				end else begin
					e = expected_samples.pop_front();
					if (e.known && colour !== e.colour) begin
						$error("colour: expected %h, actual %h", e.colour, colour);
						errors++;
					end
					if (face !== e.face) begin
						$error("face: expected %0d, actual %0d", e.face, face);
						errors++;
					end
				end
			end
			pending = expected_samples.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// Top of the wall texture sampler testbench: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
module tb_top;
	import rwts_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 30;
	localparam int FILL_PER_FACE = 128;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_write = 0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;
	logic                 in_valid = 0;
	logic                 in_stall;
	logic                 command = 0;
	logic [13:0]          texel_address = '0;
	logic [31:0]          texel_data = '0;
	logic [25:0]          player_x = '0;
	logic [25:0]          player_y = '0;
	logic signed [17:0]   ray_dir_x = '0;
	logic signed [17:0]   ray_dir_y = '0;
	logic [25:0]          wall_distance = '0;
	logic                 hit_side = 0;
	logic [11:0]          screen_row = '0;
	logic signed [15:0]   strip_top = '0;
	logic [15:0]          strip_rows = 16'd1;
	logic                 out_valid;
	logic                 out_stall = 0;
	logic [31:0]          colour;
	logic [1:0]           face;
	int                   errors;
	int                   pending;
	int                   tx_idle_pct = 0;
	int                   rx_idle_pct = 0;
	int                   hold_left = 0;
	int                   quiet_cycles = 0;
	bit                   pressure_go = 0;

	always #5 clk = ~clk;

	raycast_wall_texture_sampler DUT (.*);

	rwts_checker scoreboard (.*);

	// Receiver stall pattern, with one long hold-off when asked.
	always @(negedge clk) begin
		if (pressure_go && hold_left == 0) begin
			hold_left = 400;
			pressure_go = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer_request();
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_texel(logic [13:0] addr, logic [31:0] data);
		command <= CMD_LOAD;
		texel_address <= addr;
		texel_data <= data;
		offer_request();
	endtask

	task automatic sample_wall(logic [25:0] px, logic [25:0] py, logic signed [17:0] dx,
			logic signed [17:0] dy, logic [25:0] wdist, logic side, logic [11:0] row,
			logic signed [15:0] start, logic [15:0] height);
		command <= CMD_SAMPLE;
		texel_address <= 14'($urandom);
		texel_data <= $urandom;
		player_x <= px;
		player_y <= py;
		ray_dir_x <= dx;
		ray_dir_y <= dy;
		wall_distance <= wdist;
		hit_side <= side;
		screen_row <= row;
		strip_top <= start;
		strip_rows <= height;
		offer_request();
	endtask

	task automatic random_sample();
		logic [25:0]        px, py, wdist;
		logic signed [17:0] dx, dy;
		logic [11:0]        row;
		logic signed [15:0] start;
		logic [15:0]        height;
		px = 26'($urandom);
		py = 26'($urandom);
		if ($urandom_range(3) == 0) begin
			dx = 18'($urandom);
			dy = 18'($urandom);
			wdist = 26'($urandom);
		end else begin
			dx = 18'($signed($urandom_range(131072)) - 65536);
			dy = 18'($signed($urandom_range(131072)) - 65536);
			wdist = 26'($urandom_range(20 << 16));
		end
		row = 12'($urandom);
		case ($urandom_range(3))
			0: begin
				start = 16'($urandom);
				height = 16'($urandom);
			end
			default: begin
				start = 16'(int'(row) - int'($urandom_range(300)) + 20);
				height = 16'($urandom_range(300));
			end
		endcase
		sample_wall(px, py, dx, dy, wdist, 1'($urandom_range(1)), row, start, height);
	endtask

	task automatic write_dims(logic [DIM_W-1:0] v [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= REG_IDX_W'(i);
			cfg_data <= v[i];
			@(negedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	// Loads give no result, so the pipeline may still be busy once nothing is pending.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 20)
				load_texel(14'($urandom), $urandom);
			else
				random_sample();
		end
	endtask

	initial begin
		logic [DIM_W-1:0] d [NUM_REGS];
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill the low texels of every face; the random phases pick widths up to 16 and
		// heights up to 8, so every texel they can reach lies there.
		for (int fc = 0; fc < 4; fc++)
			for (int o = 0; o < FILL_PER_FACE; o++)
				load_texel(14'(fc * TEXELS_PER_FACE_DEF + o),
					(fc == 0 && o == 0) ? 32'hFFFF_FFFF : $urandom);

		// Directed samples at reset dimensions.
		sample_wall('0, '0, '0, '0, '0, 1'b0, '0, '0, 16'd1);
		sample_wall('1, '1, 18'sh1FFFF, 18'sh1FFFF, '1, 1'b1, '1, 16'sh8000, 16'hFFFF);
		sample_wall('1, '1, 18'sh20000, 18'sh20000, '1, 1'b1, '1, 16'sh7FFF, 16'd1);
		sample_wall('1, '1, 18'sh20000, 18'sh20000, '1, 1'b0, 12'd5, 16'sh8000, 16'd1);
		sample_wall(26'h18000, 26'h28000, 18'sh10000, 18'sh10000, 26'h10000, 1'b1,
			12'd100, 16'sd50, 16'd100);
		sample_wall(26'h18000, 26'h28000, 18'sh10000, -18'sh10000, 26'h10000, 1'b1,
			12'd100, 16'sd50, 16'd100);
		sample_wall(26'h18000, 26'h28000, -18'sh8000, 18'sh8000, 26'h20000, 1'b0,
			12'd100, 16'sd50, 16'd100);
		sample_wall(26'h18000, 26'h28000, 18'sh8000, 18'sh8000, 26'h20000, 1'b0,
			12'd100, 16'sd50, 16'd100);
		// Row above the strip, integer hit position, y past the edge, zero wall height.
		sample_wall(26'h30000, 26'h30000, 18'sh4000, 18'sh4000, 26'h8000, 1'b1,
			12'd10, 16'sd20, 16'd40);
		sample_wall(26'h30000, 26'h30000, '0, '0, 26'h8000, 1'b1, 12'd200, 16'sd0, 16'd1);
		sample_wall(26'h30000, 26'h30000, '0, -18'sd1, 26'h8000, 1'b0, 12'd4095,
			16'sd0, 16'd0);
		sample_wall(26'h12345, 26'h3ABCD, -18'sd1, -18'sd1, 26'h1, 1'b1, 12'd60,
			16'sd0, 16'd64);
		// The last texel of the west face, read back through the mirrored corner.
		load_texel(14'(3 * TEXELS_PER_FACE_DEF - 1), 32'h0000_0000);
		sample_wall('0, '0, -18'sd1, -18'sd1, '0, 1'b0, 12'd4095, -16'sd32768, 16'd1);
		drain();

		// Extreme dimensions: zero, one, full, and above the face size.
		d = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd127, 7'd0, 7'd64, 7'd1};
		write_dims(d);
		for (int i = 0; i < 12; i++)
			random_sample();
		sample_wall('1, '1, 18'sh20000, 18'sh20000, '1, 1'b0, '1, 16'sh8000, 16'd1);
		drain();

		// Sender idles rarely, receiver often; a long hold-off fills the pipeline.
		for (int i = 0; i < NUM_REGS; i++)
			d[i] = (i % 2 == 0) ? 7'($urandom_range(1, 16)) : 7'($urandom_range(1, 8));
		write_dims(d);
		tx_idle_pct = 24;
		rx_idle_pct = 69;
		pressure_go = 1;
		random_phase(500);
		drain();

		for (int i = 0; i < NUM_REGS; i++)
			d[i] = (i % 2 == 0) ? 7'($urandom_range(16)) : 7'($urandom_range(8));
		write_dims(d);
		tx_idle_pct = 69;
		rx_idle_pct = 24;
		random_phase(500);
		drain();

		for (int i = 0; i < NUM_REGS; i++) begin
			if (i % 2 == 0)
				d[i] = ($urandom_range(1)) ? 7'd16 : 7'($urandom_range(1, 16));
			else
				d[i] = ($urandom_range(1)) ? 7'd8 : 7'($urandom_range(1, 8));
		end
		write_dims(d);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(450);
		drain();

		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
